// ----- src/mlp_pkg.sv -----
// ----------------------------------------------------------------------------
// mlp_pkg
// Shared types and constants for the memory-in-pixel LCD line packer.
// ----------------------------------------------------------------------------
`default_nettype none

package mlp_pkg;

    localparam int unsigned IN_TDATA_W  = 48;  // 32 pixel + 10 line, padded to bytes
    localparam int unsigned OUT_TDATA_W = 8;
    localparam int unsigned OUT_TUSER_W = 2;   // last_of_item, status
    localparam int unsigned CFG_W       = 10;
    localparam int unsigned LINE_W      = 10;
    localparam int unsigned POS_W       = 10;
    localparam int unsigned MAX_RES     = 7;

    // Longest line the position counter supports
    localparam logic [POS_W-1:0] MAX_PIXELS = 10'd1023;
    localparam logic [POS_W-1:0] MIN_PIXELS = 10'd2;

    // Configuration register indexes
    localparam logic CFG_PIXELS_PER_LINE = 1'b0;
    localparam logic CFG_LINE_COUNT      = 1'b1;

    localparam logic [CFG_W-1:0] PPL_RESET = 10'd400;
    localparam logic [CFG_W-1:0] LC_RESET  = 10'd240;

    localparam logic [7:0] MODE_UPDATE  = 8'h01;
    localparam logic [1:0] ADDR_HI_MASK = 2'h3;

    // One item's worth of result bytes, emitted in order from entry 0
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [2:0]              cnt;       // number of results, 0 = none
        logic                    frame_end; // set on the last result
        logic                    err;       // line number out of range
    } t_job;

endpackage

`default_nettype wire

// ----- src/mlp_packer.sv -----
// ----------------------------------------------------------------------------
// mlp_packer
// Configuration registers, line/bit packing state and result-list builder.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_packer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_idx,
    input  wire logic [mlp_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire logic                                i_accept,
    input  wire logic [31:0]                         i_pixel_word,
    input  wire logic [mlp_pkg::LINE_W-1:0]          i_line_number,
    output mlp_pkg::t_job                            o_job
);

    logic [mlp_pkg::CFG_W-1:0] r_ppl, r_lc;
    logic [mlp_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                r_acc, n_acc;
    logic [2:0]                r_fill, n_fill;

    logic                      err;
    logic [2:0]                v;
    logic [15:0]               tmp;
    logic [3:0]                total;
    logic                      full;
    logic [7:0]                acc_new;
    logic [2:0]                fill_new;
    logic [mlp_pkg::POS_W-1:0] len;
    logic [mlp_pkg::POS_W:0]   pos_inc;
    logic                      line_end;
    logic                      pad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppl <= mlp_pkg::PPL_RESET;
            r_lc  <= mlp_pkg::LC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mlp_pkg::CFG_PIXELS_PER_LINE: r_ppl <= i_cfg_data;
                mlp_pkg::CFG_LINE_COUNT:      r_lc  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        err   = (i_line_number >= r_lc);
        v     = {i_pixel_word[16], i_pixel_word[8], i_pixel_word[0]};
        // Append three bits MSB first below the pending ones
        tmp   = {r_acc, 8'h00} | ({13'd0, v} << (4'd13 - {1'b0, r_fill}));
        total = {1'b0, r_fill} + 4'd3;
        full  = (total >= 4'd8);
        if (full) begin
            acc_new  = tmp[7:0];
            fill_new = total[2:0];
        end else begin
            acc_new  = tmp[15:8];
            fill_new = total[2:0];
        end

        if (r_ppl > mlp_pkg::MAX_PIXELS) begin
            len = mlp_pkg::MAX_PIXELS;
        end else if (r_ppl < mlp_pkg::MIN_PIXELS) begin
            len = mlp_pkg::MIN_PIXELS;
        end else begin
            len = r_ppl;
        end
        pos_inc  = {1'b0, r_pos} + 11'd1;
        line_end = (pos_inc >= {1'b0, len});
        pad      = line_end && (fill_new != 3'd0);

        o_job = '0;
        if (err) begin
            o_job.cnt = 3'd1;
            o_job.err = 1'b1;
        end else if (r_pos == '0) begin
            // Line header; a line holds at least two pixels, so no data here
            o_job.bytes[0] = mlp_pkg::MODE_UPDATE;
            o_job.bytes[5] = {6'd0, i_line_number[9:8] & mlp_pkg::ADDR_HI_MASK};
            o_job.bytes[6] = i_line_number[7:0];
            o_job.cnt      = 3'd7;
        end else begin
            // Dummy bytes are zero and need no entries of their own
            if (full) begin
                o_job.bytes[0] = tmp[15:8];
            end else if (pad) begin
                o_job.bytes[0] = acc_new;
            end
            if (full && pad) begin
                o_job.bytes[1] = acc_new;
            end
            o_job.cnt = {2'd0, full}
                      + (line_end ? (3'd2 + {2'd0, pad}) : 3'd0);
            o_job.frame_end = line_end;
        end

        if (err) begin
            n_pos  = r_pos;
            n_acc  = r_acc;
            n_fill = r_fill;
        end else if (line_end) begin
            n_pos  = '0;
            n_acc  = '0;
            n_fill = '0;
        end else begin
            n_pos  = pos_inc[mlp_pkg::POS_W-1:0];
            n_acc  = acc_new;
            n_fill = fill_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_acc  <= '0;
            r_fill <= '0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_acc  <= n_acc;
            r_fill <= n_fill;
        end
    end

endmodule

`default_nettype wire

// ----- src/mlp_emitter.sv -----
// ----------------------------------------------------------------------------
// mlp_emitter
// Holds one item's result list and walks it into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_emitter (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_load,
    input  wire mlp_pkg::t_job                     i_job,
    output logic                                   o_slot_ready,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [mlp_pkg::OUT_TDATA_W-1:0]        o_m_tdata,
    output logic                                   o_m_tlast,
    output logic [mlp_pkg::OUT_TUSER_W-1:0]        o_m_tuser
);

    mlp_pkg::t_job r_job;
    logic          r_jv;
    logic [2:0]    r_idx;
    logic          r_ov;
    logic [7:0]    r_byte;
    logic          r_fe, r_loi, r_st;

    logic          out_free;
    logic          take;
    logic          last_sel;

    always_comb begin
        out_free     = !r_ov || i_m_tready;
        take         = r_jv && out_free;
        last_sel     = (r_idx == (r_job.cnt - 3'd1));
        o_slot_ready = !r_jv || (take && last_sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jv  <= 1'b0;
            r_idx <= '0;
        end else if (i_load) begin
            r_jv  <= 1'b1;
            r_idx <= '0;
        end else if (take && last_sel) begin
            r_jv  <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (take) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= r_job.bytes[r_idx];
            r_fe   <= r_job.frame_end && last_sel;
            r_loi  <= last_sel;
            r_st   <= r_job.err;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_byte;
    assign o_m_tlast  = r_fe;
    assign o_m_tuser  = {r_st, r_loi};

endmodule

`default_nettype wire

// ----- src/mip_lcd_line_packer.sv -----
// ----------------------------------------------------------------------------
// mip_lcd_line_packer
// Builds the SPI byte stream for a memory-in-pixel LCD 3-bit RGB line update.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one pixel per transfer, tdata = pixel_word[31:0],
//   line_number[41:32]. Master stream: one SPI byte per transfer; tlast marks
//   the last byte of a line update (chip select drops after it).
//   Configuration: write pixels_per_line (index 0) or line_count (index 1)
//   through i_cfg_we/i_cfg_idx/i_cfg_data while the block is idle.
//   Path: the first byte caused by a pixel is held in the result-list register,
//   then in the output register.
//   Throughput: one pixel per cycle while each pixel causes at most one byte
//   and m_axis_tready is high; a pixel with more bytes holds the input until
//   the single output register (one byte a cycle while m_axis_tready is high)
//   has sent them all; 7-byte header at line start, up to 4 bytes at line end.
//   Reset: both registers return to 400 pixels and 240 lines, the line state
//   is cleared and no result is pending.
//   Stall: when m_axis_tready is low the output byte holds, the pending list
//   waits, and s_axis_tready drops once a new list has no place.
// ----------------------------------------------------------------------------
`default_nettype none

module mip_lcd_line_packer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_idx,
    input  wire logic [mlp_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [31:0] pixel_word, [41:32] line_number, [47:42] zero
    input  wire logic [mlp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [7:0] out_byte
    output logic [mlp_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    output logic                                     m_axis_tlast,
    // [0] last_of_item, [1] status
    output logic [mlp_pkg::OUT_TUSER_W-1:0]          m_axis_tuser
);

    mlp_pkg::t_job job;
    logic          accept;
    logic          slot_ready;

    assign s_axis_tready = slot_ready;
    assign accept        = s_axis_tvalid && slot_ready;

    mlp_packer u_packer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_pixel_word  (s_axis_tdata[31:0]),
        .i_line_number (s_axis_tdata[41:32]),
        .o_job         (job)
    );

    mlp_emitter u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept && (job.cnt != 3'd0)),
        .i_job        (job),
        .o_slot_ready (slot_ready),
        .o_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_m_tdata    (m_axis_tdata),
        .o_m_tlast    (m_axis_tlast),
        .o_m_tuser    (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- src/mlp_checker.sv -----
// ----------------------------------------------------------------------------
// mlp_checker
// Port-level checks for the line packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic [mlp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  wire logic                                m_axis_tlast,
    input  wire logic [mlp_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);

    // Stalled output transfer holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // Line end is always the closing byte of its pixel
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0] && !m_axis_tuser[1])
        else $error("frame end not on last byte of item");

    // Error result is a lone zero byte
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tuser[0] && !m_axis_tlast && (m_axis_tdata == '0))
        else $error("malformed error result");

    // Nothing pending right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind mip_lcd_line_packer mlp_checker u_mlp_checker (.*);

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the memory-in-pixel LCD line packer. Pixels go in on
// the slave stream and the SPI line-update bytes are checked on the master
// stream against a bit-exact line packing model kept in the bench. A directed
// table covers field extremes, line-length and line-count corners and the
// green bit that crosses a byte boundary. Random phases follow with new
// register settings, random idle on both sides and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import mlp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 10;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT_ITEM = 28;

    localparam logic ST_OK       = 1'b0;
    localparam logic ST_BAD_LINE = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
        logic       last;
        logic       status;
    } spi_byte_t;

    typedef enum logic [1:0] {
        ROW_PIXEL,
        ROW_REJECT,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        cfg_idx;
        logic [9:0]  cfg_val;
        logic [31:0] pix;
        logic [9:0]  line;
    } row_t;

    localparam int NROWS = 32;

    // ROW_REJECT rows carry their result directly: one status byte, no data.
    row_t plan [NROWS] = '{
        '{ROW_REJECT, 1'b0, 10'd0, 32'h0000_0000, 10'd1023},
        '{ROW_REJECT, 1'b0, 10'd0, 32'hFFFF_FFFF, 10'd240},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'h0001_0101, 10'd239},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'hFFFF_FFFF, 10'd5},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'h0000_0000, 10'd0},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'h0000_0100, 10'd0},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'h0001_0001, 10'd0},
        // sixth pixel lands at bit offset 7: green and blue spill over
        '{ROW_PIXEL,  1'b0, 10'd0, 32'h0000_0101, 10'd0},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'hFFFE_FEFE, 10'd100},
        // shorten the line below the current position
        '{ROW_CFG,    CFG_PIXELS_PER_LINE, 10'd3, 32'h0, 10'd0},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'h0001_0000, 10'd1},
        '{ROW_CFG,    CFG_PIXELS_PER_LINE, 10'd0, 32'h0, 10'd0},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'hFFFF_FFFF, 10'd17},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'h0001_0100, 10'd17},
        '{ROW_CFG,    CFG_PIXELS_PER_LINE, 10'd1, 32'h0, 10'd0},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'h0000_0001, 10'd200},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'h0000_0100, 10'd200},
        '{ROW_CFG,    CFG_LINE_COUNT, 10'd0, 32'h0, 10'd0},
        '{ROW_REJECT, 1'b0, 10'd0, 32'h0000_0000, 10'd0},
        '{ROW_CFG,    CFG_LINE_COUNT, 10'd1023, 32'h0, 10'd0},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'h0001_0101, 10'd1022},
        '{ROW_REJECT, 1'b0, 10'd0, 32'hFFFF_FFFF, 10'd1023},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'h0000_0000, 10'd1022},
        // eight pixels fill exactly three bytes, so no padded byte
        '{ROW_CFG,    CFG_PIXELS_PER_LINE, 10'd8, 32'h0, 10'd0},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'hFFFF_FFFF, 10'd512},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'h0001_0000, 10'd512},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'h0000_0100, 10'd512},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'h0000_0001, 10'd512},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'hFFFF_FFFF, 10'd512},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'h0000_0000, 10'd512},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'h0001_0101, 10'd512},
        '{ROW_PIXEL,  1'b0, 10'd0, 32'h0001_0001, 10'd511}
    };

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic                   i_cfg_idx     = 1'b0;
    logic [CFG_W-1:0]       i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    // packer model state and its copy of the registers
    logic [9:0] len_reg;
    logic [9:0] nlines_reg;
    logic [9:0] line_pos;
    logic [7:0] pend_bits;
    logic [2:0] pend_cnt;

    spi_byte_t spi_byte_q[$];
    spi_byte_t want;
    int        err_count   = 0;
    int        cycle_count = 0;
    int        tx_count    = 0;
    logic      tx_steady   = 1'b0;

    mip_lcd_line_packer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    // Work out the bytes one accepted pixel causes and queue them.
    task automatic pack_pixel(input logic [31:0] pix, input logic [9:0] line);
        spi_byte_t   res [MAX_RES];
        int          n;
        int          total;
        int          eff_len;
        logic [15:0] merged;
        logic [2:0]  rgb;
        n = 0;
        if (line >= nlines_reg) begin
            spi_byte_q.push_back('{8'h00, 1'b0, 1'b1, ST_BAD_LINE});
            return;
        end
        if (line_pos == 10'd0) begin
            res[0] = '{MODE_UPDATE, 1'b0, 1'b0, ST_OK};
            res[1] = '{8'h00, 1'b0, 1'b0, ST_OK};
            res[2] = '{8'h00, 1'b0, 1'b0, ST_OK};
            res[3] = '{8'h00, 1'b0, 1'b0, ST_OK};
            res[4] = '{8'h00, 1'b0, 1'b0, ST_OK};
            res[5] = '{{6'd0, line[9:8] & ADDR_HI_MASK}, 1'b0, 1'b0, ST_OK};
            res[6] = '{line[7:0], 1'b0, 1'b0, ST_OK};
            n = 7;
        end
        rgb    = {pix[16], pix[8], pix[0]};
        merged = {pend_bits, 8'h00} | (16'(rgb) << (13 - int'(pend_cnt)));
        total  = int'(pend_cnt) + 3;
        if (total >= 8) begin
            res[n] = '{merged[15:8], 1'b0, 1'b0, ST_OK};
            n++;
            pend_bits = merged[7:0];
            pend_cnt  = 3'(total - 8);
        end else begin
            pend_bits = merged[15:8];
            pend_cnt  = 3'(total);
        end
        eff_len = int'(len_reg);
        if (eff_len > int'(MAX_PIXELS)) eff_len = int'(MAX_PIXELS);
        if (eff_len < int'(MIN_PIXELS)) eff_len = int'(MIN_PIXELS);
        if (int'(line_pos) + 1 >= eff_len) begin
            // flush partial byte, then two dummy bytes; chip select drops after
            if (pend_cnt != 3'd0) begin
                res[n] = '{pend_bits, 1'b0, 1'b0, ST_OK};
                n++;
            end
            res[n]     = '{8'h00, 1'b0, 1'b0, ST_OK};
            res[n + 1] = '{8'h00, 1'b1, 1'b0, ST_OK};
            n += 2;
            line_pos  = '0;
            pend_bits = '0;
            pend_cnt  = '0;
        end else begin
            line_pos = line_pos + 10'd1;
        end
        if (n > 0) res[n - 1].last = 1'b1;
        for (int k = 0; k < n; k++) spi_byte_q.push_back(res[k]);
    endtask

    task automatic offer_pixel(input logic [31:0] pix, input logic [9:0] line,
                               input logic reject);
        int gap;
        if (tx_count % 16 == 0) tx_steady = ($urandom_range(0, 3) == 0);
        gap = tx_steady ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {{(IN_TDATA_W - 42){1'b0}}, line, pix};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (reject) spi_byte_q.push_back('{8'h00, 1'b0, 1'b1, ST_BAD_LINE});
        else pack_pixel(pix, line);
        tx_count++;
    endtask

    // Registers change only once the output has drained.
    task automatic write_reg(input logic idx, input logic [9:0] val);
        s_axis_tvalid <= 1'b0;
        while (spi_byte_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PIXELS_PER_LINE) len_reg = val;
        else nlines_reg = val;
    endtask

    initial begin : stim
        logic [9:0] cur_line;
        logic [9:0] line;
        logic [9:0] ppl;
        logic [9:0] lc;
        len_reg    = PPL_RESET;
        nlines_reg = LC_RESET;
        line_pos   = '0;
        pend_bits  = '0;
        pend_cnt   = '0;
        cur_line   = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) write_reg(plan[r].cfg_idx, plan[r].cfg_val);
            else offer_pixel(plan[r].pix, plan[r].line, plan[r].kind == ROW_REJECT);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                2: begin
                    ppl = MAX_PIXELS;
                    lc  = 10'd1023;
                end
                5: begin
                    ppl = 10'($urandom_range(2, 12));
                    lc  = 10'd1;
                end
                6: begin
                    ppl = 10'($urandom_range(0, 1));
                    lc  = 10'($urandom_range(1, 1023));
                end
                default: begin
                    ppl = 10'($urandom_range(2, 12));
                    lc  = 10'($urandom_range(1, 1023));
                end
            endcase
            write_reg(CFG_PIXELS_PER_LINE, ppl);
            write_reg(CFG_LINE_COUNT, lc);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // pick a fresh valid line at each line start
                if (line_pos == 10'd0 && nlines_reg != 10'd0)
                    cur_line = 10'($urandom_range(0, int'(nlines_reg) - 1));
                if ($urandom_range(0, 7) == 0) line = 10'($urandom_range(0, 1023));
                else line = cur_line;
                offer_pixel($urandom, line, 1'b0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (spi_byte_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : rx_side
        int   hold;
        int   got;
        logic rx_steady;
        logic long_done;
        got       = 0;
        rx_steady = 1'b0;
        long_done = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (got % 20 == 0) rx_steady = ($urandom_range(0, 3) == 0);
            // one long hold-off while pixels still come, so the block backs up
            if (!long_done && tx_count >= HOLD_AT_ITEM) begin
                hold      = LONG_HOLD;
                long_done = 1'b1;
            end else begin
                hold = rx_steady ? 0 : $urandom_range(0, 14);
            end
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (spi_byte_q.size() == 0) begin
                report($sformatf("unexpected byte %02h", m_axis_tdata));
            end else begin
                want = spi_byte_q.pop_front();
                if (m_axis_tdata !== want.data)
                    report($sformatf("byte %02h, want %02h", m_axis_tdata, want.data));
                if (m_axis_tlast !== want.frame_end)
                    report($sformatf("frame end %b, want %b", m_axis_tlast, want.frame_end));
                if (m_axis_tuser[0] !== want.last)
                    report($sformatf("last of item %b, want %b", m_axis_tuser[0], want.last));
                if (m_axis_tuser[1] !== want.status)
                    report($sformatf("status %b, want %b", m_axis_tuser[1], want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule

`default_nettype wire
